FILE: hdl/srat_pkg.sv
// Shared types, sizes and codes for the sorted range address translator.
// No dependencies; imported by srat_ram users and the top level.
package srat_pkg;

   // Table and address sizing
   localparam int TABLE_DEPTH = 256;
   localparam int ADDR_WIDTH  = 48;
   localparam int IDX_WIDTH   = $clog2(TABLE_DEPTH);
   localparam int CNT_WIDTH   = $clog2(TABLE_DEPTH + 1);
   localparam int STAT_WIDTH  = 3;

   typedef logic [ADDR_WIDTH-1:0] addr_type;
   typedef logic [IDX_WIDTH-1:0]  idx_type;
   typedef logic [CNT_WIDTH-1:0]  cnt_type;
   typedef logic [STAT_WIDTH-1:0] status_type;

   // One stored region
   typedef struct packed {
      addr_type base;
      addr_type target;
      addr_type length;
   } entry_type;

   // Operation codes
   localparam logic CMD_INSERT    = 1'b0;
   localparam logic CMD_TRANSLATE = 1'b1;

   // Response status codes
   localparam status_type ST_HIT      = 3'd0;
   localparam status_type ST_MISS     = 3'd1;
   localparam status_type ST_INSERTED = 3'd2;
   localparam status_type ST_DUP      = 3'd3;
   localparam status_type ST_BYPASS   = 3'd4;
   localparam status_type ST_FULL     = 3'd5;

   // Sequencer states
   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_SEARCH = 7'b0000010,
      S_CMP    = 7'b0000100,
      S_RANGE  = 7'b0001000,
      S_SHIFT  = 7'b0010000,
      S_SHWR   = 7'b0100000,
      S_DONE   = 7'b1000000
   } state_type;

endpackage

FILE: hdl/srat_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module srat_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port; hold data when idle
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/sorted_range_address_translator_core.sv
// Top level of the sorted range address translator: sequencer, request and
// response registers, bypass register. Depends on srat_pkg and srat_ram.
//
// Usage:
//   req_ channel carries one command per transaction: insert a region
//   (base, translated base, length) or translate a client address.
//   rsp_ channel returns one result per request: the address and a status.
//   csr_ channel writes the bypass bit; it is always ready.
// Operation:
//   The table sits in one RAM with a registered read port; every probe of
//   the binary search is a read then a compare, plus, for a translate, a
//   range check when the probed base lies below the address. An insert
//   moves each entry above the new slot up by one, a read then a write.
//   Bypass requests skip the search. One request is in flight at a time;
//   req_ready is high only while the sequencer waits for work.
// Reset:
//   Clears the entry count, bypass bit and all handshake state; table
//   contents need no clearing since only entries below the count are read.
// Stalls:
//   A finished result sits in the response register while the next request
//   is taken; the sequencer holds the following result until rsp_ready.
module sorted_range_address_translator_core
   import srat_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_cmd,
   input  addr_type   req_client_addr,
   input  addr_type   req_device_addr,
   input  addr_type   req_region_len,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output addr_type   rsp_result_addr,
   output status_type rsp_status,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_wdata
);

   // Control registers
   state_type state_ff, state_in;
   cnt_type   count_ff, count_in;
   logic      bypass_ff, bypass_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // Working registers
   cnt_type    lo_ff, lo_in;
   cnt_type    hi_ex_ff, hi_ex_in;
   idx_type    mid_ff, mid_in;
   cnt_type    ptr_ff, ptr_in;
   logic       cmd_ff, cmd_in;
   addr_type   caddr_ff, caddr_in;
   addr_type   daddr_ff, daddr_in;
   addr_type   rlen_ff, rlen_in;
   addr_type   off_ff, off_in;
   addr_type   res_addr_ff, res_addr_in;
   status_type res_status_ff, res_status_in;
   addr_type   rsp_addr_ff, rsp_addr_in;
   status_type rsp_status_ff, rsp_status_in;

   // RAM port signals
   logic      ram_wr_en;
   idx_type   ram_wr_addr;
   entry_type ram_wr_data;
   logic      ram_rd_en;
   idx_type   ram_rd_addr;
   entry_type ram_rd_data;

   // Search arithmetic
   logic [CNT_WIDTH:0] mid_sum;
   cnt_type            mid_c;
   cnt_type            mid_next;
   cnt_type            ptr_m1;

   assign mid_sum  = {1'b0, lo_ff} + {1'b0, hi_ex_ff} - {{CNT_WIDTH{1'b0}}, 1'b1};
   assign mid_c    = mid_sum[CNT_WIDTH:1];
   assign mid_next = {1'b0, mid_ff} + CNT_WIDTH'(1);
   assign ptr_m1   = ptr_ff - CNT_WIDTH'(1);

   srat_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Sequencer next state
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      bypass_in     = bypass_ff;
      rsp_valid_in  = rsp_valid_ff;
      lo_in         = lo_ff;
      hi_ex_in      = hi_ex_ff;
      mid_in        = mid_ff;
      ptr_in        = ptr_ff;
      cmd_in        = cmd_ff;
      caddr_in      = caddr_ff;
      daddr_in      = daddr_ff;
      rlen_in       = rlen_ff;
      off_in        = off_ff;
      res_addr_in   = res_addr_ff;
      res_status_in = res_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = mid_ff;
      ram_wr_data   = ram_rd_data;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = mid_ff;

      // Take a bypass write
      if (csr_valid) begin
         bypass_in = csr_wdata;
      end

      // Drop a delivered response
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in   = req_cmd;
               caddr_in = req_client_addr;
               daddr_in = req_device_addr;
               rlen_in  = req_region_len;
               lo_in    = '0;
               hi_ex_in = count_ff;
               if (bypass_ff) begin
                  if (req_cmd == CMD_TRANSLATE) begin
                     res_addr_in   = req_client_addr;
                     res_status_in = ST_MISS;
                  end else begin
                     res_addr_in   = '0;
                     res_status_in = ST_BYPASS;
                  end
                  state_in = S_DONE;
               end else begin
                  state_in = S_SEARCH;
               end
            end
         end

         S_SEARCH: begin
            if (lo_ff < hi_ex_ff) begin
               // Probe the middle entry
               ram_rd_en   = 1'b1;
               ram_rd_addr = mid_c[IDX_WIDTH-1:0];
               mid_in      = mid_c[IDX_WIDTH-1:0];
               state_in    = S_CMP;
            end else if (cmd_ff == CMD_TRANSLATE) begin
               res_addr_in   = caddr_ff;
               res_status_in = ST_MISS;
               state_in      = S_DONE;
            end else if (count_ff >= CNT_WIDTH'(TABLE_DEPTH)) begin
               res_addr_in   = '0;
               res_status_in = ST_FULL;
               state_in      = S_DONE;
            end else begin
               ptr_in   = count_ff;
               state_in = S_SHIFT;
            end
         end

         S_CMP: begin
            if (ram_rd_data.base > caddr_ff) begin
               hi_ex_in = {1'b0, mid_ff};
               state_in = S_SEARCH;
            end else if (ram_rd_data.base < caddr_ff) begin
               if (cmd_ff == CMD_TRANSLATE) begin
                  off_in   = caddr_ff - ram_rd_data.base;
                  state_in = S_RANGE;
               end else begin
                  lo_in    = mid_next;
                  state_in = S_SEARCH;
               end
            end else if (cmd_ff == CMD_TRANSLATE) begin
               res_addr_in   = ram_rd_data.target;
               res_status_in = ST_HIT;
               state_in      = S_DONE;
            end else begin
               // Duplicate base: overwrite the translated base only
               ram_wr_en          = 1'b1;
               ram_wr_addr        = mid_ff;
               ram_wr_data        = ram_rd_data;
               ram_wr_data.target = daddr_ff;
               res_addr_in        = '0;
               res_status_in      = ST_DUP;
               state_in           = S_DONE;
            end
         end

         S_RANGE: begin
            if (off_ff < ram_rd_data.length) begin
               res_addr_in   = ram_rd_data.target + off_ff;
               res_status_in = ST_HIT;
               state_in      = S_DONE;
            end else begin
               lo_in    = mid_next;
               state_in = S_SEARCH;
            end
         end

         S_SHIFT: begin
            if (ptr_ff > lo_ff) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = ptr_m1[IDX_WIDTH-1:0];
               state_in    = S_SHWR;
            end else begin
               // Place the new region in the opened slot
               ram_wr_en          = 1'b1;
               ram_wr_addr        = lo_ff[IDX_WIDTH-1:0];
               ram_wr_data.base   = caddr_ff;
               ram_wr_data.target = daddr_ff;
               ram_wr_data.length = rlen_ff;
               count_in           = count_ff + CNT_WIDTH'(1);
               res_addr_in        = '0;
               res_status_in      = ST_INSERTED;
               state_in           = S_DONE;
            end
         end

         S_SHWR: begin
            // Move one entry up by a slot
            ram_wr_en   = 1'b1;
            ram_wr_addr = ptr_ff[IDX_WIDTH-1:0];
            ram_wr_data = ram_rd_data;
            ptr_in      = ptr_m1;
            state_in    = S_SHIFT;
         end

         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = res_addr_ff;
               rsp_status_in = res_status_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         bypass_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         bypass_ff    <= bypass_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and search registers
   always_ff @(posedge clock) begin
      lo_ff         <= lo_in;
      hi_ex_ff      <= hi_ex_in;
      mid_ff        <= mid_in;
      ptr_ff        <= ptr_in;
      cmd_ff        <= cmd_in;
      caddr_ff      <= caddr_in;
      daddr_ff      <= daddr_in;
      rlen_ff       <= rlen_in;
      off_ff        <= off_in;
      res_addr_ff   <= res_addr_in;
      res_status_ff <= res_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_ready       = (state_ff == S_IDLE);
   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_addr = rsp_addr_ff;
   assign rsp_status      = rsp_status_ff;

   // The entry count never passes the table depth
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_WIDTH'(TABLE_DEPTH))
      else $error("entry count beyond table depth");

   // The count moves only when a new region is placed
   a_count_stable : assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_SHIFT) |=> $stable(count_ff))
      else $error("entry count changed outside insert");

   // Insert outcomes always return a zero address
   a_insert_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == ST_INSERTED || rsp_status_ff == ST_DUP ||
       rsp_status_ff == ST_BYPASS || rsp_status_ff == ST_FULL))
      |-> (rsp_addr_ff == '0))
      else $error("insert response with non-zero address");

   // A shift write only happens above the insert slot
   a_shift_above : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHWR) |-> (ptr_ff > lo_ff))
      else $error("shift write at or below insert slot");

   // A waiting response is never overwritten
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> (rsp_valid_ff && $stable(rsp_addr_ff) &&
       $stable(rsp_status_ff)))
      else $error("stalled response lost");

endmodule
